[hdl/assert_macros.svh]
// Assertion macros shared by the RTL of the TCP header compressor.
// Depends on nothing; users must provide signals clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define THC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define THC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/thc_pkg.sv]
// Package for the TCP header compressor: constants, payload and internal types.
// Depends on nothing; every module of the block imports it.
package thc_pkg;

    // Flow context store geometry (power of two).
    localparam int NUM_SLOTS = 256;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);

    // Protocol constants.
    localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
    localparam logic [7:0]  PROTO_TCP       = 8'd6;
    localparam logic [11:0] FIXED_HDR_BYTES = 12'd40;
    localparam logic [11:0] OPT_FIELD_BYTES = 12'd4;
    localparam logic [10:0] MAX_LEN         = 11'h7FF;

    // Configuration register reset values.
    localparam logic [10:0] MIN_LEN_RST   = 11'd100;
    localparam logic [15:0] CMP_ETYPE_RST = 16'd34997;
    localparam logic [6:0]  CMP_HDR_RST   = 7'd16;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CMP_ETYPE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CMP_HDR   = 2'd2;

    typedef enum logic [1:0] {
        ACT_PASS     = 2'd0,
        ACT_NEW_FLOW = 2'd1,
        ACT_COMPRESS = 2'd2
    } action_t;

    typedef struct packed {
        logic [15:0] eth_type;
        logic [7:0]  ip_protocol;
        logic [10:0] frame_length;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [31:0] sequence_number;
        logic [31:0] ack_number;
    } hdr_item_t;

    typedef struct packed {
        action_t     action;
        logic [7:0]  slot_index;
        logic        seq_changed;
        logic        ack_changed;
        logic [10:0] out_length;
        logic [15:0] out_ethertype;
    } res_item_t;

    // One flow context entry.
    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] seq;
        logic [31:0] ack;
    } slot_entry_t;

    // Write request from the match logic to the context store.
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        slot_entry_t       entry;
    } slot_wr_t;

    // Current configuration.
    typedef struct packed {
        logic [10:0] min_len;
        logic [15:0] cmp_etype;
        logic [6:0]  cmp_hdr;
    } thc_cfg_t;

endpackage

[hdl/tcp_header_compressor.sv]
// TCP/IPv4 header compressor, flow context stage.
// Header transfers come in on hdr/hdr_valid/hdr_stall and result transfers go out on
// res/res_valid/res_stall; a transfer happens on a rising edge with valid high and
// stall low. Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high and unknown indexes are ignored.
// Every header gives exactly one result, in order. A header taken is held in the input
// stage register and then in the result register, and one header per cycle is sustained
// while the receiver does not stall: the context memory is read as the header is
// registered, then compared and rewritten as it advances, with a bypass for same-slot frames.
// When the receiver stalls, the result register holds; the stage in front of it
// holds too and hdr_stall rises only once that stage is full.
// Reset (rst_n low, asynchronous) empties the pipeline, loads the configuration
// defaults and marks every context slot empty (reads as all zero), with no sweep.
// Depends on thc_pkg, thc_slot_store, thc_flow_match and assert_macros.svh.
`include "assert_macros.svh"

module tcp_header_compressor (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             hdr_valid,
    output logic                             hdr_stall,
    input  thc_pkg::hdr_item_t               hdr,
    output logic                             res_valid,
    input  logic                             res_stall,
    output thc_pkg::res_item_t               res,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [thc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [15:0]                      cfg_data
);
    import thc_pkg::*;

    thc_cfg_t     cfg_reg;
    hdr_item_t    st_item_reg;
    logic         st_valid_reg;
    res_item_t    res_reg;
    logic         res_valid_reg;

    logic         st_adv;
    logic         hdr_acc;
    slot_entry_t  entry;
    res_item_t    match_res;
    slot_wr_t     match_wr;
    slot_wr_t     store_wr;

    // Pipeline flow control.
    assign st_adv    = !res_valid_reg || !res_stall;
    assign hdr_stall = st_valid_reg && !st_adv;
    assign hdr_acc   = hdr_valid && !hdr_stall;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_len   <= MIN_LEN_RST;
            cfg_reg.cmp_etype <= CMP_ETYPE_RST;
            cfg_reg.cmp_hdr   <= CMP_HDR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MIN_LEN:   cfg_reg.min_len   <= cfg_data[10:0];
                CFG_CMP_ETYPE: cfg_reg.cmp_etype <= cfg_data;
                CFG_CMP_HDR:   cfg_reg.cmp_hdr   <= cfg_data[6:0];
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    // Input stage register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= 1'b0;
        end
        else if (!hdr_stall)
        begin
            st_valid_reg <= hdr_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hdr_acc)
        begin
            st_item_reg <= hdr;
        end
    end

    // Context store, read as each header is registered.
    assign store_wr.en    = match_wr.en && st_valid_reg && st_adv;
    assign store_wr.slot  = match_wr.slot;
    assign store_wr.entry = match_wr.entry;

    thc_slot_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (hdr_acc),
        .rd_slot  (hdr.source_address[SLOT_W-1:0]),
        .wr       (store_wr),
        .rd_entry (entry)
    );

    thc_flow_match u_match (
        .hdr   (st_item_reg),
        .entry (entry),
        .cfg   (cfg_reg),
        .res   (match_res),
        .wr    (match_wr)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (st_adv)
        begin
            res_valid_reg <= st_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_adv && st_valid_reg)
        begin
            res_reg <= match_res;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // A compressed result carries the configured ethertype.
    `THC_ASSERT(a_cmp_etype,
        res_valid && (res.action == ACT_COMPRESS) |-> res.out_ethertype == cfg_reg.cmp_etype,
        "compressed result with wrong ethertype")
    // A passed frame has no slot and no change flags.
    `THC_ASSERT(a_pass_clean,
        res_valid && (res.action == ACT_PASS)
            |-> (res.slot_index == 8'd0) && !res.seq_changed && !res.ack_changed,
        "pass result with slot or flags set")
    // A full stage that cannot advance keeps its item.
    `THC_ASSERT(a_stage_hold, st_valid_reg && !st_adv |=> st_valid_reg,
        "stalled stage lost its item")
    // The input is never stalled while the stage is empty.
    `THC_ASSERT_ALWAYS(a_no_idle_stall, !st_valid_reg |-> !hdr_stall,
        "input stalled with empty stage")

endmodule

[hdl/thc_slot_store.sv]
// Flow context store: 256-entry memory with per-entry valid bits and a write bypass.
// Depends on thc_pkg.
module thc_slot_store (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rd_en,
    input  logic [thc_pkg::SLOT_W-1:0] rd_slot,
    input  thc_pkg::slot_wr_t     wr,
    output thc_pkg::slot_entry_t  rd_entry
);
    import thc_pkg::*;

    slot_entry_t            mem [NUM_SLOTS];
    slot_entry_t            rd_data_reg;
    slot_entry_t            fwd_entry_reg;
    logic                   fwd_reg;
    logic                   vld_cap_reg;
    logic [NUM_SLOTS-1:0]   vld_reg;

    // Memory write port.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.slot] <= wr.entry;
        end
    end

    // Registered memory read; the bypass copy covers a write at the same edge.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg   <= mem[rd_slot];
            fwd_entry_reg <= wr.entry;
        end
    end

    // Valid bits stand in for the all-zero reset contents.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            fwd_reg     <= 1'b0;
            vld_cap_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr.slot] <= 1'b1;
            end
            if (rd_en)
            begin
                fwd_reg     <= wr.en && (wr.slot == rd_slot);
                vld_cap_reg <= vld_reg[rd_slot];
            end
        end
    end

    // Entry seen by the match logic.
    always_comb
    begin
        if (fwd_reg)
        begin
            rd_entry = fwd_entry_reg;
        end
        else if (vld_cap_reg)
        begin
            rd_entry = rd_data_reg;
        end
        else
        begin
            rd_entry = '0;
        end
    end

endmodule

[hdl/thc_flow_match.sv]
// Flow match and result logic: classifies a header, compares it with its context
// entry, forms the result and the context update. Depends on thc_pkg.
module thc_flow_match (
    input  thc_pkg::hdr_item_t    hdr,
    input  thc_pkg::slot_entry_t  entry,
    input  thc_pkg::thc_cfg_t     cfg,
    output thc_pkg::res_item_t    res,
    output thc_pkg::slot_wr_t     wr
);
    import thc_pkg::*;

    logic              eligible;
    logic              tuple_hit;
    logic              seq_chg;
    logic              ack_chg;
    logic [SLOT_W-1:0] slot;
    logic [11:0]       len_sum;
    logic [11:0]       len_diff;
    logic [10:0]       len_cmp;

    // Only IPv4/TCP frames of sufficient length use a context.
    assign eligible = (hdr.eth_type == ETHERTYPE_IPV4) && (hdr.ip_protocol == PROTO_TCP)
                      && (hdr.frame_length >= cfg.min_len);
    assign slot     = hdr.source_address[SLOT_W-1:0];

    assign tuple_hit = (entry.src_addr == hdr.source_address)
                       && (entry.dst_addr == hdr.dest_address)
                       && (entry.src_port == hdr.source_port)
                       && (entry.dst_port == hdr.dest_port);
    assign seq_chg = (entry.seq != hdr.sequence_number);
    assign ack_chg = (entry.ack != hdr.ack_number);

    // Compressed length, clamped to the 11-bit range.
    always_comb
    begin
        len_sum  = 12'(hdr.frame_length) + 12'(cfg.cmp_hdr)
                   + (seq_chg ? OPT_FIELD_BYTES : 12'd0)
                   + (ack_chg ? OPT_FIELD_BYTES : 12'd0);
        len_diff = len_sum - FIXED_HDR_BYTES;
        if (len_sum < FIXED_HDR_BYTES)
        begin
            len_cmp = '0;
        end
        else if (len_diff > 12'(MAX_LEN))
        begin
            len_cmp = MAX_LEN;
        end
        else
        begin
            len_cmp = len_diff[10:0];
        end
    end

    // Result selection.
    always_comb
    begin
        res.action        = ACT_PASS;
        res.slot_index    = '0;
        res.seq_changed   = 1'b0;
        res.ack_changed   = 1'b0;
        res.out_length    = hdr.frame_length;
        res.out_ethertype = hdr.eth_type;
        if (eligible)
        begin
            res.slot_index = 8'(slot);
            if (tuple_hit)
            begin
                res.action        = ACT_COMPRESS;
                res.seq_changed   = seq_chg;
                res.ack_changed   = ack_chg;
                res.out_length    = len_cmp;
                res.out_ethertype = cfg.cmp_etype;
            end
            else
            begin
                res.action = ACT_NEW_FLOW;
            end
        end
    end

    // A miss records the whole tuple; a hit refreshes seq and ack, which is the same entry.
    assign wr.en             = eligible;
    assign wr.slot           = slot;
    assign wr.entry.src_addr = hdr.source_address;
    assign wr.entry.dst_addr = hdr.dest_address;
    assign wr.entry.src_port = hdr.source_port;
    assign wr.entry.dst_port = hdr.dest_port;
    assign wr.entry.seq      = hdr.sequence_number;
    assign wr.entry.ack      = hdr.ack_number;

endmodule
